/* hw/rtl/rafe_pkg.sv */
// ----------------------------------------------------------------------------
// rafe_pkg
// Shared types and opcode constants for the ALU/flags execute block.
// ----------------------------------------------------------------------------
package rafe_pkg;

    localparam logic [5:0] OP_ADD    = 6'd0;
    localparam logic [5:0] OP_ADDC   = 6'd1;
    localparam logic [5:0] OP_ADDQ   = 6'd2;
    localparam logic [5:0] OP_ADDQT  = 6'd3;
    localparam logic [5:0] OP_SUB    = 6'd4;
    localparam logic [5:0] OP_SUBC   = 6'd5;
    localparam logic [5:0] OP_SUBQ   = 6'd6;
    localparam logic [5:0] OP_SUBQT  = 6'd7;
    localparam logic [5:0] OP_NEG    = 6'd8;
    localparam logic [5:0] OP_AND    = 6'd9;
    localparam logic [5:0] OP_OR     = 6'd10;
    localparam logic [5:0] OP_XOR    = 6'd11;
    localparam logic [5:0] OP_NOT    = 6'd12;
    localparam logic [5:0] OP_BTST   = 6'd13;
    localparam logic [5:0] OP_BSET   = 6'd14;
    localparam logic [5:0] OP_BCLR   = 6'd15;
    localparam logic [5:0] OP_MULT   = 6'd16;
    localparam logic [5:0] OP_IMULT  = 6'd17;
    localparam logic [5:0] OP_IMULTN = 6'd18;
    localparam logic [5:0] OP_RESMAC = 6'd19;
    localparam logic [5:0] OP_IMACN  = 6'd20;
    localparam logic [5:0] OP_DIV    = 6'd21;
    localparam logic [5:0] OP_ABS    = 6'd22;
    localparam logic [5:0] OP_SH     = 6'd23;
    localparam logic [5:0] OP_SHLQ   = 6'd24;
    localparam logic [5:0] OP_SHRQ   = 6'd25;
    localparam logic [5:0] OP_SHA    = 6'd26;
    localparam logic [5:0] OP_SHARQ  = 6'd27;
    localparam logic [5:0] OP_ROR    = 6'd28;
    localparam logic [5:0] OP_RORQ   = 6'd29;
    localparam logic [5:0] OP_CMP    = 6'd30;
    localparam logic [5:0] OP_CMPQ   = 6'd31;
    localparam logic [5:0] OP_SAT8   = 6'd32;
    localparam logic [5:0] OP_SAT16  = 6'd33;
    localparam logic [5:0] OP_MOVE   = 6'd34;
    localparam logic [5:0] OP_MOVEQ  = 6'd35;
    localparam logic [5:0] OP_JUMP   = 6'd52;
    localparam logic [5:0] OP_JR     = 6'd53;
    localparam logic [5:0] OP_SAT24  = 6'd62;
    localparam logic [5:0] OP_PACK   = 6'd63;
    localparam logic [5:0] OP_SEXT   = 6'd55;

    localparam int DIV_STEPS = 48;

    typedef struct packed {
        logic [5:0]  op;
        logic [31:0] d;
        logic [31:0] s;
        logic [4:0]  imm;
        logic [4:0]  cc;
        logic        is_div;
    } rafe_cmd_t;

    typedef struct packed {
        logic [31:0] result;
        logic        write_result;
        logic        zero_flag;
        logic        negative_flag;
        logic        carry_flag;
        logic        branch_taken;
        logic [31:0] remainder_out;
    } rafe_res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } rafe_state_t;

endpackage

/* hw/rtl/risc_alu_flags_execute.sv */
// ----------------------------------------------------------------------------
// risc_alu_flags_execute
// Execute stage of a 32-bit RISC coprocessor: ALU, flags, MAC and divider.
// ----------------------------------------------------------------------------
// Requests enter on s_axis (tdata: op[5:0], dest_value[37:6], src_value[69:38],
// imm_first[74:70], cond_code[79:75]) and leave on m_axis, one result per
// request, in order. A two-entry queue decouples the front from the back.
// The back takes one request from the queue at a time: a request is queued,
// popped into cmd_reg and then executed into the output register; a division
// with nonzero divisor first passes through the bit-serial divider (ST_DIV).
// The back takes no new request until the previous result is registered and
// the output is not stalled.
// cfg_valid/cfg_ready writes div_fraction_mode; write only while idle.
// Reset clears the flags, accumulator, remainder, queue and mode.
// When m_axis_tready is low the result holds; the queue keeps taking
// requests until it is full, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module risc_alu_flags_execute
    import rafe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // op, dest_value, src_value, imm_first, cond_code
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // result, write_result, zero_flag,
                                        // negative_flag, carry_flag, branch_taken,
                                        // remainder_out, zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    logic      frac_reg;
    logic      q_valid, q_ready;
    rafe_cmd_t q_cmd;
    rafe_res_t res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) frac_reg <= 1'b0;
        else if (cfg_valid) frac_reg <= cfg_data;
    end

    rafe_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .op(s_axis_tdata[5:0]), .d(s_axis_tdata[37:6]), .s(s_axis_tdata[69:38]),
        .imm(s_axis_tdata[74:70]), .cc(s_axis_tdata[79:75]),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    rafe_back u_back (
        .clk(clk), .rst_n(rst_n), .frac_mode(frac_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res)
    );

    assign m_axis_tdata = {3'd0, res.remainder_out, res.branch_taken, res.carry_flag,
                           res.negative_flag, res.zero_flag, res.write_result,
                           res.result};

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_branch_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && res.branch_taken |-> !res.write_result)
        else $error("branch request writes a register");
    a_full_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> q_valid)
        else $error("front stalled with empty queue");

endmodule

/* hw/rtl/rafe_front.sv */
// ----------------------------------------------------------------------------
// rafe_front
// Accepts requests, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module rafe_front
    import rafe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [5:0]  op,
    input  logic [31:0] d,
    input  logic [31:0] s,
    input  logic [4:0]  imm,
    input  logic [4:0]  cc,
    output logic        q_valid,
    input  logic        q_ready,
    output rafe_cmd_t   q_cmd
);

    rafe_cmd_t  mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = mem_reg[rptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= '{op: op, d: d, s: s, imm: imm, cc: cc,
                                   is_div: (op == OP_DIV) && (s != 32'd0)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop)  rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

/* hw/rtl/rafe_divider.sv */
// ----------------------------------------------------------------------------
// rafe_divider
// Restoring radix-2 divider, one quotient bit per cycle over 48 bits.
// ----------------------------------------------------------------------------
module rafe_divider
    import rafe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        frac,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [31:0] quot,
    output logic [31:0] rem
);

    logic [47:0] q_reg, q_next;
    logic [32:0] r_reg, r_next;
    logic [31:0] den_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [32:0] trial;

    assign trial = {r_reg[31:0], q_reg[47]};
    assign done  = busy_reg && (cnt_reg == 6'd0);
    assign quot  = q_reg[31:0];
    assign rem   = r_reg[31:0];

    always_comb
    begin
        q_next = {q_reg[46:0], 1'b0};
        r_next = trial;
        if (trial >= {1'b0, den_reg})
        begin
            r_next    = trial - {1'b0, den_reg};
            q_next[0] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= frac ? {num, 16'd0} : {16'd0, num};
            r_reg   <= '0;
            den_reg <= den;
        end
        else if (busy_reg && cnt_reg != 6'd0)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 6'(DIV_STEPS);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 6'd0) busy_reg <= 1'b0;
            else cnt_reg <= cnt_reg - 6'd1;
        end
    end

endmodule

/* hw/rtl/rafe_back.sv */
// ----------------------------------------------------------------------------
// rafe_back
// Executes queued requests, keeps flags, accumulator and remainder.
// ----------------------------------------------------------------------------
module rafe_back
    import rafe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        frac_mode,
    input  logic        q_valid,
    output logic        q_ready,
    input  rafe_cmd_t   q_cmd,
    output logic        out_valid,
    input  logic        out_ready,
    output rafe_res_t   out_res
);

    rafe_state_t state_reg, state_next;
    logic z_reg, n_reg, c_reg;
    logic [31:0] mac_reg, rem_reg;
    rafe_cmd_t   cmd_reg;
    rafe_res_t   res_reg;
    logic [31:0] prod_reg;
    logic [31:0] d, s, r, quick, sv, diff, p;
    logic [4:0]  imm;
    logic [32:0] w;
    logic wr, zn, br, zf, nf, cf, fsel, take, start, div_done;
    logic [31:0] quot, dvrem;
    logic out_valid_hold;
    logic exec;
    logic ov_reg;

    // multiply registered at queue pop; used when the request executes in ST_OUT
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= q_cmd;
            if (q_cmd.op == OP_MULT)
                prod_reg <= {16'd0, q_cmd.d[15:0]} * {16'd0, q_cmd.s[15:0]};
            else
                prod_reg <= 32'($signed(q_cmd.d[15:0]) * $signed(q_cmd.s[15:0]));
        end
    end

    assign take    = (state_reg == ST_IDLE) && q_valid && !out_valid_hold;
    assign q_ready = take;
    assign start   = take && q_cmd.is_div;

    assign exec = (state_reg == ST_OUT) && !out_valid_hold;

    rafe_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(start), .frac(frac_mode),
        .num(q_cmd.d), .den(q_cmd.s), .done(div_done), .quot(quot), .rem(dvrem)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (take) state_next = q_cmd.is_div ? ST_DIV : ST_OUT;
            ST_DIV:  if (div_done) state_next = ST_OUT;
            ST_OUT:  if (exec) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    function automatic logic [31:0] shl(input logic [31:0] v, input logic [31:0] n);
        shl = (n >= 32'd32) ? 32'd0 : v << n[4:0];
    endfunction
    function automatic logic [31:0] shr(input logic [31:0] v, input logic [31:0] n);
        shr = (n >= 32'd32) ? 32'd0 : v >> n[4:0];
    endfunction
    function automatic logic [31:0] sar(input logic [31:0] v, input logic [31:0] n);
        sar = (n >= 32'd32) ? {32{v[31]}} : 32'($signed(v) >>> n[4:0]);
    endfunction
    function automatic logic [31:0] rotr(input logic [31:0] v, input logic [4:0] n);
        logic [63:0] t;
        t = {v, v} >> n;
        rotr = t[31:0];
    endfunction
    function automatic logic [31:0] sat(input logic [31:0] v, input logic [31:0] top);
        sat = v[31] ? 32'd0 : ((v > top) ? top : v);
    endfunction

    always_comb
    begin
        d = cmd_reg.d; s = cmd_reg.s; imm = cmd_reg.imm;
        quick = (imm == 5'd0) ? 32'd32 : {27'd0, imm};
        r = d; wr = 1'b0; zn = 1'b0; br = 1'b0;
        zf = z_reg; nf = n_reg; cf = c_reg;
        w = '0; sv = '0; diff = '0; p = prod_reg;
        fsel = cmd_reg.cc[4] ? n_reg : c_reg;
        unique case (cmd_reg.op)
            OP_ADD, OP_ADDC, OP_ADDQ:
            begin
                w = {1'b0, d} + {1'b0, (cmd_reg.op == OP_ADDQ) ? quick : s}
                    + {32'd0, (cmd_reg.op == OP_ADDC) & c_reg};
                r = w[31:0]; cf = w[32]; wr = 1'b1; zn = 1'b1;
            end
            OP_ADDQT: begin r = d + quick; wr = 1'b1; end
            OP_SUB, OP_SUBC, OP_SUBQ:
            begin
                w = {1'b0, d} - {1'b0, (cmd_reg.op == OP_SUBQ) ? quick : s}
                    - {32'd0, (cmd_reg.op == OP_SUBC) & c_reg};
                r = w[31:0]; cf = w[32]; wr = 1'b1; zn = 1'b1;
            end
            OP_SUBQT: begin r = d - quick; wr = 1'b1; end
            OP_NEG: begin cf = (d != 32'd0); r = 32'd0 - d; wr = 1'b1; zn = 1'b1; end
            OP_AND: begin r = d & s; wr = 1'b1; zn = 1'b1; end
            OP_OR:  begin r = d | s; wr = 1'b1; zn = 1'b1; end
            OP_XOR: begin r = d ^ s; wr = 1'b1; zn = 1'b1; end
            OP_NOT: begin r = ~d; wr = 1'b1; zn = 1'b1; end
            OP_BTST: zf = ~d[imm];
            OP_BSET: begin r = d | (32'd1 << imm); wr = 1'b1; zn = 1'b1; end
            OP_BCLR: begin r = d & ~(32'd1 << imm); wr = 1'b1; zn = 1'b1; end
            OP_MULT, OP_IMULT: begin r = p; wr = 1'b1; zn = 1'b1; end
            OP_IMULTN: begin zf = (p == 32'd0); nf = p[31]; end
            OP_RESMAC: begin r = mac_reg; wr = 1'b1; end
            OP_DIV: if (cmd_reg.is_div) begin r = quot; wr = 1'b1; end
            OP_ABS:
            begin
                cf = d[31]; r = d[31] ? 32'd0 - d : d;
                zf = (r == 32'd0); nf = 1'b0; wr = 1'b1;
            end
            OP_SH, OP_SHA:
            begin
                if (s[31]) begin cf = d[31]; r = shl(d, 32'd0 - s); end
                else
                begin
                    cf = d[0];
                    r = (cmd_reg.op == OP_SH) ? shr(d, s) : sar(d, s);
                end
                wr = 1'b1; zn = 1'b1;
            end
            OP_SHLQ: begin cf = d[31]; r = shl(d, 32'd32 - {27'd0, imm});
                wr = 1'b1; zn = 1'b1; end
            OP_SHRQ: begin cf = d[0]; r = shr(d, quick); wr = 1'b1; zn = 1'b1; end
            OP_SHARQ: begin cf = d[0]; r = sar(d, quick); wr = 1'b1; zn = 1'b1; end
            OP_ROR: begin cf = d[31]; r = rotr(d, s[4:0]); wr = 1'b1; zn = 1'b1; end
            OP_RORQ: begin cf = d[31]; r = rotr(d, imm); wr = 1'b1; zn = 1'b1; end
            OP_CMP, OP_CMPQ:
            begin
                sv = (cmd_reg.op == OP_CMP) ? s : {{27{imm[4]}}, imm};
                diff = d - sv; cf = (d < sv);
                zf = (diff == 32'd0); nf = diff[31];
            end
            OP_SAT8, OP_SAT16, OP_SAT24:
            begin
                r = sat(d, (cmd_reg.op == OP_SAT8) ? 32'd255 :
                    ((cmd_reg.op == OP_SAT16) ? 32'd65535 : 32'd16777215));
                zf = (r == 32'd0); nf = 1'b0; wr = 1'b1;
            end
            OP_MOVE: begin r = s; wr = 1'b1; end
            OP_MOVEQ: begin r = {27'd0, imm}; wr = 1'b1; end
            OP_JUMP, OP_JR:
                br = !((cmd_reg.cc[0] && z_reg) || (cmd_reg.cc[1] && !z_reg) ||
                       (cmd_reg.cc[2] && fsel) || (cmd_reg.cc[3] && !fsel));
            OP_SEXT:
            begin
                r = (d & 32'h007F_FFFF) | (d[31] ? 32'hFF80_0000 : 32'd0);
                wr = 1'b1; zn = 1'b1;
            end
            OP_PACK:
            begin
                if (imm == 5'd0)
                    r = ((d & 32'h03C0_0000) >> 10) | ((d & 32'h0001_E000) >> 5)
                        | (d & 32'hFF);
                else
                    r = ((d & 32'h0000_F000) << 10) | ((d & 32'h0000_0F00) << 5)
                        | (d & 32'hFF);
                wr = 1'b1;
            end
            default: ;
        endcase
        if (zn) begin zf = (r == 32'd0); nf = r[31]; end
        if (!wr) r = d;
    end

    assign out_valid_hold = out_valid && !out_ready;
    assign out_valid = ov_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk)
    begin
        if (exec)
            res_reg <= '{result: r, write_result: wr, zero_flag: zf, negative_flag: nf,
                        carry_flag: cf, branch_taken: br,
                        remainder_out: (cmd_reg.op == OP_DIV && cmd_reg.is_div)
                                       ? dvrem : rem_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg <= 1'b0;
            z_reg <= 1'b0; n_reg <= 1'b0; c_reg <= 1'b0;
            mac_reg <= '0; rem_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (exec) ov_reg <= 1'b1;
            else if (out_ready) ov_reg <= 1'b0;
            if (exec)
            begin
                z_reg <= zf; n_reg <= nf; c_reg <= cf;
                if (cmd_reg.op == OP_IMULTN) mac_reg <= p;
                if (cmd_reg.op == OP_IMACN)  mac_reg <= mac_reg + p;
                if (cmd_reg.op == OP_DIV && cmd_reg.is_div) rem_reg <= dvrem;
            end
        end
    end

endmodule
